[rtl/core/svf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svf_pkg
// Shared constants, types and the digit encoder for the seven-segment
// value formatter.
// ----------------------------------------------------------------------------
package svf_pkg;

   // request function codes
   localparam logic [2:0] FUNC_NUMBER = 3'd0;
   localparam logic [2:0] FUNC_TENTHS = 3'd1;
   localparam logic [2:0] FUNC_TIME   = 3'd2;
   localparam logic [2:0] FUNC_TEMP   = 3'd3;
   localparam logic [2:0] FUNC_ERROR  = 3'd4;
   localparam logic [2:0] FUNC_ON     = 3'd5;
   localparam logic [2:0] FUNC_OFF    = 3'd6;
   localparam logic [2:0] FUNC_BRIGHT = 3'd7;

   // csr register indexes
   localparam logic CSR_DIM_LEVEL  = 1'b0;
   localparam logic CSR_FULL_LEVEL = 1'b1;

   localparam logic [2:0] DIM_LEVEL_RST  = 3'd2;
   localparam logic [2:0] FULL_LEVEL_RST = 3'd7;

   // controller command bytes and special segments
   localparam logic [7:0] CMD_DATA  = 8'h40;
   localparam logic [7:0] CMD_ADDR  = 8'hC0;
   localparam logic [7:0] CMD_CTRL  = 8'h80;
   localparam logic [7:0] SEG_C     = 8'b0011_1001;
   localparam logic [7:0] SEG_E     = 8'b0111_1001;
   localparam logic [7:0] SEG_MINUS = 8'b0100_0000;
   localparam logic [7:0] SEG_COMMA = 8'b0001_0000;
   localparam logic [7:0] SEG_COLON = 8'h80;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   // position of each byte in the seven-byte refresh
   localparam logic [2:0] BYTE_DATA = 3'd0;
   localparam logic [2:0] BYTE_ADDR = 3'd1;
   localparam logic [2:0] BYTE_SEG0 = 3'd2;
   localparam logic [2:0] BYTE_SEG1 = 3'd3;
   localparam logic [2:0] BYTE_SEG2 = 3'd4;
   localparam logic [2:0] BYTE_SEG3 = 3'd5;
   localparam logic [2:0] BYTE_CTRL = 3'd6;

   localparam int VALUE_W = 15;
   localparam int MAG_W   = 14;   // magnitude up to 9999

   // floor(r / 10) == (r * RECIP_TEN) >> RECIP_SHIFT for r < 16000
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // one formatted refresh, seg[0] is the left digit
   typedef struct packed {
      logic [3:0][7:0] seg;
      logic [7:0]      ctrl;
   } entry_type;

   function automatic logic [7:0] seg_digit(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

[rtl/core/svf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svf_front
// Request intake: display state, saturation, digit pipeline and formatting.
// ----------------------------------------------------------------------------
module svf_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            func,
   input  wire logic [14:0]           value,
   input  wire logic [4:0]            hour,
   input  wire logic [5:0]            minute,
   input  wire logic                  bright_request,
   input  wire logic                  csr_we,
   input  wire logic                  csr_addr,
   input  wire logic [2:0]            csr_wdata,
   output svf_pkg::entry_type         push_entry,
   output logic                       push,
   input  wire logic                  queue_full
);

   typedef struct packed {
      logic [2:0]                      mode;
      logic                            neg;
      logic [7:0]                      ctrl;
      logic [svf_pkg::MAG_W-1:0]       rem;
      logic [2:0][3:0]                 dig;   // units, tens, hundreds
   } stage_type;

   localparam int PROD_W = svf_pkg::MAG_W + svf_pkg::RECIP_W;
   localparam int QUOT_W = PROD_W - svf_pkg::RECIP_SHIFT;

   logic [2:0]  dim_level_ff, dim_level_in;
   logic [2:0]  full_level_ff, full_level_in;
   logic [2:0]  mode_ff, mode_in;
   logic signed [svf_pkg::VALUE_W-1:0] value_ff, value_in;
   logic        on_ff, on_in;
   logic        bright_ff, bright_in;

   logic [3:0]  vld_ff, vld_in;
   stage_type   stg_ff [0:3];
   stage_type   stg_in [0:3];
   logic [PROD_W-1:0] prod [1:3];
   logic [QUOT_W-1:0] quot [1:3];
   logic [svf_pkg::MAG_W-1:0] rest [1:3];

   logic        advance, accept, emit;
   logic signed [svf_pkg::VALUE_W-1:0] v_s, hm;
   logic [4:0]  hour_c;
   logic [5:0]  minute_c;
   logic [2:0]  lvl;
   logic [3:0]  d0, d1, d2, d3;

   assign advance   = !(vld_ff[3] && queue_full);
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign push      = vld_ff[3] && !queue_full;

   assign v_s      = $signed(value);
   assign hour_c   = (hour > 5'd23) ? 5'd23 : hour;
   assign minute_c = (minute > 6'd59) ? 6'd59 : minute;
   assign hm       = $signed(15'(hour_c) * 15'd100 + 15'(minute_c));

   // csr writes
   always_comb begin
      dim_level_in  = dim_level_ff;
      full_level_in = full_level_ff;
      if (csr_we) begin
         if (csr_addr == svf_pkg::CSR_DIM_LEVEL) dim_level_in = csr_wdata;
         if (csr_addr == svf_pkg::CSR_FULL_LEVEL) full_level_in = csr_wdata;
      end
   end

   // display state update on accept
   always_comb begin
      mode_in   = mode_ff;
      value_in  = value_ff;
      on_in     = on_ff;
      bright_in = bright_ff;
      emit      = 1'b1;
      unique case (func)
         svf_pkg::FUNC_NUMBER, svf_pkg::FUNC_TENTHS, svf_pkg::FUNC_TIME,
         svf_pkg::FUNC_TEMP, svf_pkg::FUNC_ERROR: begin
            mode_in = func;
            on_in   = 1'b1;
         end
         svf_pkg::FUNC_ON:  on_in = 1'b1;
         svf_pkg::FUNC_OFF: on_in = 1'b0;
         default: begin
            bright_in = bright_request;
            emit      = on_ff;
         end
      endcase
      unique case (func)
         svf_pkg::FUNC_NUMBER:
            value_in = (v_s < 0) ? 15'sd0 : ((v_s > 15'sd9999) ? 15'sd9999 : v_s);
         svf_pkg::FUNC_TENTHS:
            value_in = (v_s < 0) ? 15'sd0 : ((v_s > 15'sd999) ? 15'sd999 : v_s);
         svf_pkg::FUNC_TIME:
            value_in = hm;
         svf_pkg::FUNC_TEMP:
            value_in = (v_s < -15'sd99) ? -15'sd99 : ((v_s > 15'sd99) ? 15'sd99 : v_s);
         svf_pkg::FUNC_ERROR:
            value_in = (v_s < 0) ? 15'sd0 : ((v_s > 15'sd99) ? 15'sd99 : v_s);
         default: value_in = value_ff;
      endcase
   end

   assign lvl = bright_in ? full_level_ff : dim_level_ff;

   // digit pipeline: one divide by ten per stage
   always_comb begin
      vld_in        = vld_ff;
      stg_in[0]     = stg_ff[0];
      vld_in[0]     = accept && emit;
      if (accept) begin
         stg_in[0].mode = mode_in;
         stg_in[0].neg  = value_in[svf_pkg::VALUE_W-1];
         stg_in[0].ctrl = svf_pkg::CMD_CTRL | {4'b0000, on_in, lvl};
         stg_in[0].rem  = value_in[svf_pkg::VALUE_W-1]
                          ? svf_pkg::MAG_W'(-value_in)
                          : svf_pkg::MAG_W'(value_in);
         stg_in[0].dig  = '0;
      end
      for (int s = 1; s < 4; s++) begin
         prod[s]      = PROD_W'(stg_ff[s-1].rem) * PROD_W'(svf_pkg::RECIP_TEN);
         quot[s]      = prod[s][PROD_W-1:svf_pkg::RECIP_SHIFT];
         rest[s]      = stg_ff[s-1].rem - svf_pkg::MAG_W'(quot[s]) * svf_pkg::MAG_W'(10);
         vld_in[s]    = vld_ff[s-1];
         stg_in[s]    = stg_ff[s-1];
         stg_in[s].rem = svf_pkg::MAG_W'(quot[s]);
         stg_in[s].dig[s-1] = rest[s][3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_level_ff  <= svf_pkg::DIM_LEVEL_RST;
         full_level_ff <= svf_pkg::FULL_LEVEL_RST;
         mode_ff       <= svf_pkg::FUNC_NUMBER;
         value_ff      <= '0;
         on_ff         <= 1'b0;
         bright_ff     <= 1'b0;
         vld_ff        <= '0;
      end else begin
         dim_level_ff  <= dim_level_in;
         full_level_ff <= full_level_in;
         if (accept) begin
            mode_ff   <= mode_in;
            value_ff  <= value_in;
            on_ff     <= on_in;
            bright_ff <= bright_in;
         end
         if (advance) vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < 4; s++) stg_ff[s] <= stg_in[s];
      end
   end

   // formatting of the finished digits
   assign d0 = stg_ff[3].dig[0];
   assign d1 = stg_ff[3].dig[1];
   assign d2 = stg_ff[3].dig[2];
   assign d3 = stg_ff[3].rem[3:0];

   always_comb begin
      push_entry.ctrl = stg_ff[3].ctrl;
      push_entry.seg  = '0;
      unique case (stg_ff[3].mode)
         svf_pkg::FUNC_NUMBER: begin
            push_entry.seg[0] = (d3 != 4'd0) ? svf_pkg::seg_digit(d3) : svf_pkg::SEG_BLANK;
            push_entry.seg[1] = (d3 != 4'd0 || d2 != 4'd0)
                                ? svf_pkg::seg_digit(d2) : svf_pkg::SEG_BLANK;
            push_entry.seg[2] = (d3 != 4'd0 || d2 != 4'd0 || d1 != 4'd0)
                                ? svf_pkg::seg_digit(d1) : svf_pkg::SEG_BLANK;
            push_entry.seg[3] = svf_pkg::seg_digit(d0);
         end
         svf_pkg::FUNC_TIME: begin
            push_entry.seg[0] = svf_pkg::seg_digit(d3);
            push_entry.seg[1] = svf_pkg::seg_digit(d2) | svf_pkg::SEG_COLON;
            push_entry.seg[2] = svf_pkg::seg_digit(d1);
            push_entry.seg[3] = svf_pkg::seg_digit(d0);
         end
         svf_pkg::FUNC_TENTHS: begin
            push_entry.seg[0] = (d2 != 4'd0) ? svf_pkg::seg_digit(d2) : svf_pkg::SEG_BLANK;
            push_entry.seg[1] = svf_pkg::seg_digit(d1);
            push_entry.seg[2] = svf_pkg::SEG_COMMA;
            push_entry.seg[3] = svf_pkg::seg_digit(d0);
         end
         svf_pkg::FUNC_TEMP: begin
            // minus sits left of a non-zero tens digit, else in its place
            push_entry.seg[0] = (d1 != 4'd0 && stg_ff[3].neg)
                                ? svf_pkg::SEG_MINUS : svf_pkg::SEG_BLANK;
            push_entry.seg[1] = (d1 != 4'd0) ? svf_pkg::seg_digit(d1)
                              : (stg_ff[3].neg ? svf_pkg::SEG_MINUS : svf_pkg::SEG_BLANK);
            push_entry.seg[2] = svf_pkg::seg_digit(d0);
            push_entry.seg[3] = svf_pkg::SEG_C;
         end
         default: begin
            push_entry.seg[0] = svf_pkg::SEG_BLANK;
            push_entry.seg[1] = (d1 != 4'd0) ? svf_pkg::SEG_E : svf_pkg::SEG_BLANK;
            push_entry.seg[2] = (d1 != 4'd0) ? svf_pkg::seg_digit(d1) : svf_pkg::SEG_E;
            push_entry.seg[3] = svf_pkg::seg_digit(d0);
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/svf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svf_queue
// Short queue of formatted refreshes between intake and byte sender.
// ----------------------------------------------------------------------------
module svf_queue #(
   parameter int DEPTH = svf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire svf_pkg::entry_type   push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output svf_pkg::entry_type        head,
   output logic                      not_empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   svf_pkg::entry_type mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

[rtl/core/svf_sender.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svf_sender
// Walks the seven bytes of the queue head into the output register.
// ----------------------------------------------------------------------------
module svf_sender (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire svf_pkg::entry_type  head,
   input  wire logic                not_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               frame_byte,
   output logic                     start_before,
   output logic                     stop_after,
   output logic                     last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       start_ff, start_in;
   logic       stop_ff, stop_in;
   logic       last_ff, last_in;
   logic       load;
   logic [2:0] seg_off;

   assign load    = not_empty && (!valid_ff || rsp_ready);
   assign pop     = load && (idx_ff == svf_pkg::BYTE_CTRL);
   assign seg_off = idx_ff - svf_pkg::BYTE_SEG0;

   always_comb begin
      byte_in  = svf_pkg::CMD_DATA;
      start_in = 1'b1;
      stop_in  = 1'b1;
      last_in  = 1'b0;
      unique case (idx_ff) inside
         svf_pkg::BYTE_DATA: ;
         svf_pkg::BYTE_ADDR: begin
            byte_in = svf_pkg::CMD_ADDR;
            stop_in = 1'b0;
         end
         svf_pkg::BYTE_SEG0, svf_pkg::BYTE_SEG1, svf_pkg::BYTE_SEG2,
         svf_pkg::BYTE_SEG3: begin
            byte_in  = head.seg[seg_off[1:0]];
            start_in = 1'b0;
            stop_in  = (idx_ff == svf_pkg::BYTE_SEG3);
         end
         svf_pkg::BYTE_CTRL: begin
            byte_in = head.ctrl;
            last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = (idx_ff == svf_pkg::BYTE_CTRL) ? svf_pkg::BYTE_DATA : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= svf_pkg::BYTE_DATA;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign frame_byte   = byte_ff;
   assign start_before = start_ff;
   assign stop_after   = stop_ff;
   assign last         = last_ff;

endmodule
`default_nettype wire

[rtl/core/seven_segment_value_formatter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_value_formatter_top
// Formats values for a four-digit seven-segment display controller.
// ----------------------------------------------------------------------------
// Each request (number, tenths, time, temperature, error, on, off or set
// brightness) yields the seven-byte refresh frame for the display controller,
// one byte per rsp_ beat: data command, address command, four segment bytes
// (left digit first) and the display control byte. A set-brightness request
// while the display is off only updates the flag and sends nothing. The
// intake takes a request every cycle while the refresh queue has room; the
// first byte passes the input stage, three divide-by-ten stages, the queue and
// the output register. Sustained throughput is set by the result port, which
// moves one byte per cycle while rsp_tready is high. The brightness levels are
// sampled when a request is taken, so write them only while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_value_formatter_top #(
   parameter int QUEUE_DEPTH = svf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // value[14:0], hour[19:15], minute[25:20],
                                        // bright_request[26], zero fill
   input  wire logic [2:0]  req_tuser,  // func[2:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // frame_byte[7:0], start_before[8],
                                        // stop_after[9], zero fill
   output logic             rsp_tlast,  // last byte of the refresh
   // csr write port
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [2:0]  csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   svf_pkg::entry_type push_entry;   // formatted refresh into the queue
   svf_pkg::entry_type head;         // oldest refresh, being sent
   logic               push, pop, q_full, q_valid;
   logic [CNT_W-1:0]   q_level;
   logic [7:0]         frame_byte;
   logic               start_before, stop_after;

   // intake: state, saturation, digit pipeline, formatting
   svf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .func           (req_tuser),
      .value          (req_tdata[14:0]),
      .hour           (req_tdata[19:15]),
      .minute         (req_tdata[25:20]),
      .bright_request (req_tdata[26]),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .push_entry     (push_entry),
      .push           (push),
      .queue_full     (q_full)
   );

   // decouples intake from the byte sender
   svf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .not_empty  (q_valid),
      .level      (q_level)
   );

   // byte sender with output register
   svf_sender u_sender (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .not_empty    (q_valid),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .frame_byte   (frame_byte),
      .start_before (start_before),
      .stop_after   (stop_after),
      .last         (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, stop_after, start_before, frame_byte};

   // --- checks ---
   // queue occupancy stays within its depth
   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_level <= CNT_W'(QUEUE_DEPTH))
      else $error("refresh queue overfilled");

   // a refresh is only retired when one is present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty refresh queue");

   // the intake never pushes into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full refresh queue");

   // the control byte closes the refresh with start and stop
   a_last_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[8] && rsp_tdata[9]))
      else $error("last byte without start and stop");

endmodule
`default_nettype wire

[tb/seven_segment_value_formatter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_value_formatter_checker
// Watches the request, result and csr ports of the formatter, keeps its own
// copy of the display state, predicts the seven-byte refresh of each request
// and compares every result byte against the oldest prediction.
// ----------------------------------------------------------------------------
module seven_segment_value_formatter_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,  // value[14:0], hour[19:15], minute[25:20],
                                        // bright_request[26], zero fill
   input  wire logic [2:0]  req_tuser,  // func[2:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,  // frame_byte[7:0], start_before[8],
                                        // stop_after[9], zero fill
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [2:0]  csr_wdata,
   output int               mismatch_count,
   output int               bytes_pending,
   output int               bytes_checked
);
   import svf_pkg::*;

   localparam logic [7:0] DISPLAY_ON_BIT = 8'h08;
   localparam int         REPORT_LIMIT   = 10;

   // digit 9 in the top byte, digit 0 in the bottom one
   localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
      8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } frame_beat_type;

   frame_beat_type expected_bytes[$];

   // shadow of the display state and levels
   logic [2:0] shown_func;
   int         shown_value;
   logic       display_lit;
   logic       bright_selected;
   logic [2:0] dim_level;
   logic [2:0] full_level;

   initial begin
      mismatch_count = 0;
      bytes_pending  = 0;
      bytes_checked  = 0;
   end

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] digit_code(int d);
      logic [3:0] idx;
      idx = 4'(d);
      return DIGIT_SEGMENTS[idx];
   endfunction

   // plain decimal with blanked leading zeros, or clock style with all digits
   function automatic logic [3:0][7:0] decimal_segments(int num, logic clock_style);
      logic [3:0][7:0] seg;
      logic            leading;
      int              scale;
      int              d;
      leading = 1'b1;
      scale   = 1000;
      for (int k = 0; k < 4; k++) begin
         d = (num / scale) % 10;
         if (d != 0 || clock_style || !leading || k == 3) seg[k] = digit_code(d);
         else seg[k] = SEG_BLANK;
         if (d != 0) leading = 1'b0;
         if (clock_style && k == 1) seg[k] = seg[k] | SEG_COLON;
         scale = scale / 10;
      end
      return seg;
   endfunction

   function automatic logic [3:0][7:0] segments_for(logic [2:0] mode, int raw);
      logic [3:0][7:0] seg;
      int              n;
      int              mag;
      int              tens;
      case (mode)
         FUNC_NUMBER: seg = decimal_segments(clamp_int(raw, 0, 9999), 1'b0);
         FUNC_TIME:   seg = decimal_segments(clamp_int(raw, 0, 2359), 1'b1);
         FUNC_TENTHS: begin
            n      = clamp_int(raw, 0, 999);
            seg[0] = ((n / 100) % 10 != 0) ? digit_code((n / 100) % 10) : SEG_BLANK;
            seg[1] = digit_code((n / 10) % 10);
            seg[2] = SEG_COMMA;
            seg[3] = digit_code(n % 10);
         end
         FUNC_TEMP: begin
            n      = clamp_int(raw, -99, 99);
            mag    = (n < 0) ? -n : n;
            tens   = (mag / 10) % 10;
            seg[0] = SEG_BLANK;
            seg[1] = SEG_BLANK;
            if (tens != 0) begin
               seg[1] = digit_code(tens);
               if (n < 0) seg[0] = SEG_MINUS;
            end else if (n < 0) begin
               seg[1] = SEG_MINUS;
            end
            seg[2] = digit_code(mag % 10);
            seg[3] = SEG_C;
         end
         default: begin
            n      = clamp_int(raw, 0, 99);
            tens   = (n / 10) % 10;
            seg[0] = SEG_BLANK;
            if (tens != 0) begin
               seg[1] = SEG_E;
               seg[2] = digit_code(tens);
            end else begin
               seg[1] = SEG_BLANK;
               seg[2] = SEG_E;
            end
            seg[3] = digit_code(n % 10);
         end
      endcase
      return seg;
   endfunction

   task automatic push_refresh();
      logic [3:0][7:0] seg;
      logic [7:0]      ctrl;
      seg  = segments_for(shown_func, shown_value);
      ctrl = CMD_CTRL | {5'b0, bright_selected ? full_level : dim_level}
             | (display_lit ? DISPLAY_ON_BIT : 8'h00);
      expected_bytes.push_back({CMD_DATA, 1'b1, 1'b1, 1'b0});
      expected_bytes.push_back({CMD_ADDR, 1'b1, 1'b0, 1'b0});
      for (int k = 0; k < 4; k++) expected_bytes.push_back({seg[k], 1'b0, k == 3, 1'b0});
      expected_bytes.push_back({ctrl, 1'b1, 1'b1, 1'b1});
   endtask

   task automatic take_request(logic [2:0] func, logic [31:0] data);
      int value;
      int hour;
      int minute;
      value  = int'($signed(data[14:0]));
      hour   = int'(data[19:15]);
      minute = int'(data[25:20]);
      case (func)
         FUNC_NUMBER: shown_value = clamp_int(value, 0, 9999);
         FUNC_TENTHS: shown_value = clamp_int(value, 0, 999);
         FUNC_TIME:   shown_value = clamp_int(hour, 0, 23) * 100 + clamp_int(minute, 0, 59);
         FUNC_TEMP:   shown_value = clamp_int(value, -99, 99);
         FUNC_ERROR:  shown_value = clamp_int(value, 0, 99);
         FUNC_ON:     display_lit = 1'b1;
         FUNC_OFF:    display_lit = 1'b0;
         default:     bright_selected = data[26];
      endcase
      if (func <= FUNC_ERROR) begin
         shown_func  = func;
         display_lit = 1'b1;
      end
      // brightness change while dark is silent
      if (func != FUNC_BRIGHT || display_lit) push_refresh();
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         shown_func      = FUNC_NUMBER;
         shown_value     = 0;
         display_lit     = 1'b0;
         bright_selected = 1'b0;
         dim_level       = DIM_LEVEL_RST;
         full_level      = FULL_LEVEL_RST;
         expected_bytes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected frame byte %02h start %b stop %b last %b",
                           $realtime, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tlast);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata[7:0] !== want.frame_byte || rsp_tdata[8] !== want.start_before ||
                   rsp_tdata[9] !== want.stop_after || rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: byte/start/stop/last expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                              $realtime,
                              want.frame_byte, want.start_before, want.stop_after, want.last,
                              rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tlast);
               end
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_DIM_LEVEL) dim_level = csr_wdata;
            else full_level = csr_wdata;
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

[tb/seven_segment_value_formatter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_value_formatter_top_tb
// Drives the formatter with a directed set of display requests and then
// random requests under several brightness settings, with random gaps on
// both channels and one long result hold-off; the checker beside the block
// predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module seven_segment_value_formatter_top_tb;
   import svf_pkg::*;

   localparam int RUN_LIMIT_NS    = 2_000_000;  // far beyond the slowest legal run
   localparam int SETTLE_CYCLES   = 20;         // outlasts the pipeline, queue and output register
   localparam int HOLD_OFF_CYCLES = 80;         // long enough to fill the refresh queue
   localparam int IDLE_PERCENT    = 34;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // value[14:0], hour[19:15], minute[25:20],
                                   // bright_request[26], zero fill
   logic [2:0]  req_tuser  = '0;   // func[2:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // frame_byte[7:0], start_before[8], stop_after[9],
                                   // zero fill
   logic        rsp_tlast;

   logic        csr_we    = 1'b0;
   logic        csr_addr  = 1'b0;
   logic [2:0]  csr_wdata = '0;

   int          mismatch_count;
   int          bytes_pending;
   int          bytes_checked;
   int          requests_sent = 0;

   // knobs shared between the sender and the receiver
   logic        req_idle_on    = 1'b1;
   logic        rsp_idle_on    = 1'b1;
   logic        hold_off_armed = 1'b0;
   logic        hold_off_done  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   seven_segment_value_formatter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   seven_segment_value_formatter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // Offers one request and returns at the edge that accepts it. tvalid stays
   // high on return, so back-to-back requests keep the channel busy; a gap
   // lowers it first.
   task automatic send_request(logic [2:0] func, int value, int hour, int minute,
                               logic bright);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'b0, bright, 6'(minute), 5'(hour), 15'(value)};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // Mostly well-formed requests with in-range content; roughly one in seven
   // fields is raw noise so saturation gets a steady workout.
   task automatic send_random_request();
      logic [2:0] func;
      int         pick;
      int         value;
      int         hour;
      int         minute;
      pick = $urandom_range(99);
      if (pick < 72)      func = 3'($urandom_range(FUNC_ERROR, FUNC_NUMBER));
      else if (pick < 82) func = FUNC_ON;
      else if (pick < 90) func = FUNC_OFF;
      else                func = FUNC_BRIGHT;
      if ($urandom_range(99) < 15) begin
         value = int'($signed(15'($urandom)));
      end else begin
         case (func)
            FUNC_NUMBER: value = $urandom_range(9999);
            FUNC_TENTHS: value = $urandom_range(999);
            FUNC_TEMP:   value = int'($urandom_range(198)) - 99;
            FUNC_ERROR:  value = $urandom_range(99);
            default:     value = int'($signed(15'($urandom)));
         endcase
      end
      hour   = ($urandom_range(99) < 15) ? $urandom_range(31) : $urandom_range(23);
      minute = ($urandom_range(99) < 15) ? $urandom_range(63) : $urandom_range(59);
      send_request(func, value, hour, minute, 1'($urandom_range(1)));
   endtask

   // Waits until every predicted byte has come out, then a little longer in
   // case a silent brightness request is still inside the block. Returns on a
   // falling edge so the checker's counters are read away from the clock edge.
   task automatic drain_outstanding();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (bytes_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_level(logic index, logic [2:0] level);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= level;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One brightness setting: levels are only changed once the block is quiet.
   task automatic run_phase(logic [2:0] dim, logic [2:0] full, logic sender_gaps,
                            logic receiver_gaps, logic with_hold_off, int count);
      drain_outstanding();
      write_level(CSR_DIM_LEVEL, dim);
      write_level(CSR_FULL_LEVEL, full);
      req_idle_on = sender_gaps;
      rsp_idle_on = receiver_gaps;
      if (with_hold_off) hold_off_armed <= 1'b1;
      repeat (count) send_random_request();
   endtask

   // --------------------------------------------------------------------------
   // Result side: random back-pressure, and once a long hold-off counted here
   // while the sender keeps offering requests, so the refresh queue fills up
   // and req_tready drops.
   // --------------------------------------------------------------------------
   initial begin
      forever begin
         if (hold_off_armed && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready <= rsp_idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
         @(posedge clock);
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and verdict
   // --------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset levels (dim 2, full 7).
      // Brightness change while dark: flag stored, nothing sent.
      send_request(FUNC_BRIGHT, 0, 0, 0, 1'b1);
      // Switching on re-sends the reset value (number 0) at full level.
      send_request(FUNC_ON, 0, 0, 0, 1'b0);
      // Number: lone zero, inner zero after blanks, top of range, and the
      // extremes of the value field, both saturating.
      send_request(FUNC_NUMBER, 0, 0, 0, 1'b0);
      send_request(FUNC_NUMBER, 10, 0, 0, 1'b0);
      send_request(FUNC_NUMBER, 9999, 0, 0, 1'b0);
      send_request(FUNC_NUMBER, 16383, 0, 0, 1'b0);
      send_request(FUNC_NUMBER, -16384, 0, 0, 1'b0);
      // Tenths: blank hundreds, full range, saturated.
      send_request(FUNC_TENTHS, 5, 0, 0, 1'b0);
      send_request(FUNC_TENTHS, 999, 0, 0, 1'b0);
      send_request(FUNC_TENTHS, 1500, 0, 0, 1'b0);
      // Time: midnight, last minute of the day, and hour/minute fields at
      // their widest, saturating to 23:59.
      send_request(FUNC_TIME, 0, 0, 0, 1'b0);
      send_request(FUNC_TIME, 0, 23, 59, 1'b0);
      send_request(FUNC_TIME, 0, 31, 63, 1'b0);
      // Temperature: minus ahead of two digits, minus standing in for a zero
      // tens digit, single positive digit, top of range, saturated low end.
      send_request(FUNC_TEMP, -99, 0, 0, 1'b0);
      send_request(FUNC_TEMP, -5, 0, 0, 1'b0);
      send_request(FUNC_TEMP, 7, 0, 0, 1'b0);
      send_request(FUNC_TEMP, 99, 0, 0, 1'b0);
      send_request(FUNC_TEMP, -16384, 0, 0, 1'b0);
      // Error: single digit right-aligned, two digits, saturated.
      send_request(FUNC_ERROR, 7, 0, 0, 1'b0);
      send_request(FUNC_ERROR, 42, 0, 0, 1'b0);
      send_request(FUNC_ERROR, 300, 0, 0, 1'b0);
      // Brightness while lit re-sends, then off, silent change, on again.
      send_request(FUNC_BRIGHT, 0, 0, 0, 1'b0);
      send_request(FUNC_OFF, 0, 0, 0, 1'b0);
      send_request(FUNC_BRIGHT, 0, 0, 0, 1'b1);
      send_request(FUNC_ON, 0, 0, 0, 1'b0);

      // Random part over several level settings, extremes included.
      run_phase(3'd0, 3'd7, 1'b0, 1'b0, 1'b0, 34);   // no idling anywhere
      run_phase(3'd7, 3'd0, 1'b1, 1'b1, 1'b0, 36);
      run_phase(3'd0, 3'd0, 1'b0, 1'b1, 1'b1, 36);   // sender flat out into the hold-off
      run_phase(3'd7, 3'd7, 1'b1, 1'b1, 1'b0, 36);
      run_phase(3'($urandom_range(7)), 3'($urandom_range(7)), 1'b1, 1'b1, 1'b0, 44);

      drain_outstanding();

      $display("Covered %0d requests over all eight functions, six level settings",
               requests_sent);
      $display("(both extremes), random gaps and one long result hold-off; %0d bytes checked",
               bytes_checked);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout: %0d frame bytes still outstanding", bytes_pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
